/* hdl/gmvc_pkg.sv */
// shared constants, types and helper functions of the grid mask velocity clip block
package gmvc_pkg;

	// map and cell geometry
	localparam int MAP_W     = 512;
	localparam int MAP_H     = 512;
	localparam int CELL_SIZE = 6;

	// field formats
	localparam int CELL_FIELD_W = 9;
	localparam int POS_W        = 20;
	localparam int VEL_W        = 16;
	localparam int FRAC_W       = 8;

	// derived widths
	localparam int COL_W  = $clog2(MAP_W);
	localparam int ROW_W  = $clog2(MAP_H);
	localparam int UNIT_W = POS_W - FRAC_W + 1;
	localparam int CELL_W = UNIT_W + 1;
	localparam int REM_W  = (CELL_SIZE > 1) ? $clog2(CELL_SIZE) : 1;
	localparam int STEP_W = VEL_W - FRAC_W;

	// reciprocal of the cell size for the whole-unit to cell division
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int RECIP       = (2 ** RECIP_SHIFT + CELL_SIZE - 1) / CELL_SIZE;

	typedef logic        [UNIT_W-1:0] unit_t;
	typedef logic signed [CELL_W-1:0] cell_t;
	typedef logic        [REM_W-1:0]  rem_t;
	typedef logic        [MAP_W-1:0]  row_t;
	typedef logic        [ROW_W-1:0]  row_addr_t;
	typedef logic        [COL_W-1:0]  col_t;
	typedef logic signed [VEL_W-1:0]  vel_t;
	typedef logic        [STEP_W-1:0] step_t;

	// cell index and whole-unit offset inside that cell
	typedef struct packed {
		cell_t c;
		rem_t  r;
	} cell_pos_t;

	// row memory read request
	typedef struct packed {
		logic      en;
		row_addr_t addr;
	} ram_rd_t;

	// row memory write request
	typedef struct packed {
		logic      en;
		row_addr_t addr;
		row_t      data;
	} ram_wr_t;

	// one whole unit forward or back, carrying into the next cell
	function automatic cell_pos_t cell_step(cell_pos_t p, logic neg);
		cell_pos_t n;
		n = p;
		if (neg) begin
			if (p.r == '0) begin
				n.c = p.c - cell_t'(1);
				n.r = rem_t'(CELL_SIZE - 1);
			end else begin
				n.r = p.r - rem_t'(1);
			end
		end else begin
			if (p.r == rem_t'(CELL_SIZE - 1)) begin
				n.c = p.c + cell_t'(1);
				n.r = '0;
			end else begin
				n.r = p.r + rem_t'(1);
			end
		end
		return n;
	endfunction

	// number of whole-unit steps: ceiling of the velocity magnitude
	function automatic step_t step_count(vel_t v);
		logic [VEL_W:0] mag;
		logic [VEL_W:0] sum;
		if (v[VEL_W-1]) begin
			mag = (VEL_W+1)'(~v) + (VEL_W+1)'(1);
		end else begin
			mag = (VEL_W+1)'(v);
		end
		sum = mag + (VEL_W+1)'(2 ** FRAC_W - 1);
		return STEP_W'(sum >> FRAC_W);
	endfunction

	// clipped velocity: signed count of free steps with zero fraction
	function automatic vel_t clip_vel(step_t taken, logic neg);
		vel_t mag;
		mag = {taken, {FRAC_W{1'b0}}};
		return neg ? -mag : mag;
	endfunction

	function automatic logic col_in_map(cell_t c);
		return !c[CELL_W-1] && (c < cell_t'(MAP_W));
	endfunction

	function automatic logic row_in_map(cell_t c);
		return !c[CELL_W-1] && (c < cell_t'(MAP_H));
	endfunction

endpackage

/* hdl/gmvc_map_ram.sv */
// free-or-wall map storage, one map row per word, registered read
module gmvc_map_ram (
	input  logic              clk,
	input  gmvc_pkg::ram_rd_t rd,
	input  gmvc_pkg::ram_wr_t wr,
	output gmvc_pkg::row_t    rd_data
);
	import gmvc_pkg::*;

	row_t mem [MAP_H];

	// one write and one read port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

/* hdl/gmvc_div.sv */
// whole units to cell index and offset, reciprocal multiply with one register stage
module gmvc_div (
	input  logic            clk,
	input  gmvc_pkg::unit_t unit,
	output gmvc_pkg::unit_t quot,
	output gmvc_pkg::rem_t  rem
);
	import gmvc_pkg::*;

	logic [UNIT_W+RECIP_W-1:0] prod_s1;
	unit_t                     unit_s1;
	unit_t                     back;

	// multiply by the scaled reciprocal
	always_ff @(posedge clk) begin
		prod_s1 <= (UNIT_W+RECIP_W)'(unit) * (UNIT_W+RECIP_W)'(RECIP);
		unit_s1 <= unit;
	end

	// quotient and remainder
	always_comb begin
		quot = prod_s1[RECIP_SHIFT +: UNIT_W];
		back = UNIT_W'(quot * UNIT_W'(CELL_SIZE));
		rem  = REM_W'(unit_s1 - back);
	end

endmodule

/* hdl/grid_mask_velocity_clip.sv */
// top level: command port, sweep sequencer, map memory and cell divider
//
//   channel   handshake          payload
//   command   start / busy       kind, cell_x, cell_y, cell_free, pos_x, pos_y, vel_x, vel_y
//   result    done (one cycle)   new_vel_x, new_vel_y, hit_x, hit_y
//
// a map write reads the row, then writes it back with the cell replaced; off the map it skips the write back
// a query sweeps x, then y, in whole-unit steps, nx and ny the steps taken per axis (up to 128
// each); x steps scan one fetched row, each y step waits on its own row read
// done pulses in the cycle after the last query cycle; a write gives no result
// after reset a clearing pass writes all MAP_H rows to wall, one row a cycle, busy high
// the receiver cannot stall: each result transfer lasts exactly one cycle
module grid_mask_velocity_clip (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  kind,
	input  logic [gmvc_pkg::CELL_FIELD_W-1:0]     cell_x,
	input  logic [gmvc_pkg::CELL_FIELD_W-1:0]     cell_y,
	input  logic                                  cell_free,
	input  logic [gmvc_pkg::POS_W-1:0]            pos_x,
	input  logic [gmvc_pkg::POS_W-1:0]            pos_y,
	input  gmvc_pkg::vel_t                        vel_x,
	input  gmvc_pkg::vel_t                        vel_y,
	output logic                                  done,
	output gmvc_pkg::vel_t                        new_vel_x,
	output gmvc_pkg::vel_t                        new_vel_y,
	output logic                                  hit_x,
	output logic                                  hit_y
);
	import gmvc_pkg::*;

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_WR_RD  = 4'd2;
	localparam logic [3:0] ST_WR_WB  = 4'd3;
	localparam logic [3:0] ST_DIV_X  = 4'd4;
	localparam logic [3:0] ST_DIV_Y  = 4'd5;
	localparam logic [3:0] ST_ROW_X  = 4'd6;
	localparam logic [3:0] ST_X_STEP = 4'd7;
	localparam logic [3:0] ST_COL    = 4'd8;
	localparam logic [3:0] ST_Y_INIT = 4'd9;
	localparam logic [3:0] ST_Y_RD   = 4'd10;
	localparam logic [3:0] ST_Y_CHK  = 4'd11;

	// control registers
	logic [3:0] state_q;
	logic [3:0] state_d;
	row_addr_t  clr_q;
	logic       done_q;

	// captured command
	logic                    kind_q;
	logic [CELL_FIELD_W-1:0] cx_q;
	logic [CELL_FIELD_W-1:0] cy_q;
	logic                    free_q;
	logic [POS_W-1:0]        px_q;
	logic [POS_W-1:0]        py_q;
	vel_t                    vx_q;
	vel_t                    vy_q;

	// sweep working registers
	cell_pos_t cur_q;
	cell_pos_t yst_q;
	cell_pos_t nxt_q;
	step_t     step_q;
	logic      rowok_q;
	logic      colneg_q;
	logic      colok_q;
	col_t      colc_q;
	logic      off_q;

	// result registers
	vel_t new_vel_x_q;
	vel_t new_vel_y_q;
	logic hit_x_q;
	logic hit_y_q;

	// datapath signals
	logic                    accept;
	logic                    finish;
	logic                    wr_in_map;
	step_t                   nx;
	step_t                   ny;
	cell_pos_t               nxt_x;
	cell_pos_t               nxt_y;
	logic                    x_free;
	logic                    x_last;
	logic                    y_off;
	logic                    y_free;
	logic                    y_last;
	logic signed [POS_W+1:0] col_sum;
	unit_t                   div_unit;
	unit_t                   div_quot;
	rem_t                    div_rem;
	ram_rd_t                 ram_rd;
	ram_wr_t                 ram_wr;
	row_t                    rd_data;
	row_t                    row_mod;

	gmvc_map_ram u_ram (
		.clk     (clk),
		.rd      (ram_rd),
		.wr      (ram_wr),
		.rd_data (rd_data)
	);

	gmvc_div u_div (
		.clk  (clk),
		.unit (div_unit),
		.quot (div_quot),
		.rem  (div_rem)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// step decisions for both axes
	always_comb begin
		wr_in_map = (int'(cx_q) < MAP_W) && (int'(cy_q) < MAP_H);
		nx        = step_count(vx_q);
		ny        = step_count(vy_q);
		nxt_x     = cell_step(cur_q, vx_q[VEL_W-1]);
		nxt_y     = cell_step(cur_q, vy_q[VEL_W-1]);
		x_free    = rowok_q && col_in_map(nxt_x.c) && rd_data[nxt_x.c[COL_W-1:0]];
		x_last    = (step_q == nx);
		y_off     = !(colok_q && row_in_map(nxt_y.c));
		y_free    = !off_q && rd_data[colc_q];
		y_last    = (step_q == ny);
		col_sum   = $signed({2'b00, px_q}) + (POS_W+2)'(new_vel_x_q);
	end

	// divider operand select
	always_comb begin
		case (state_q)
			ST_DIV_X: div_unit = UNIT_W'(px_q[POS_W-1:FRAC_W]);
			ST_DIV_Y: div_unit = UNIT_W'(py_q[POS_W-1:FRAC_W]);
			ST_COL:   div_unit = col_sum[POS_W:FRAC_W];
			default:  div_unit = '0;
		endcase
	end

	// row with the written cell replaced
	always_comb begin
		row_mod                 = rd_data;
		row_mod[COL_W'(cx_q)]   = free_q;
	end

	// memory requests
	always_comb begin
		ram_rd = '0;
		ram_wr = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_wr.en   = 1'b1;
				ram_wr.addr = clr_q;
				ram_wr.data = '0;
			end
			ST_WR_RD: begin
				ram_rd.en   = wr_in_map;
				ram_rd.addr = ROW_W'(cy_q);
			end
			ST_WR_WB: begin
				ram_wr.en   = 1'b1;
				ram_wr.addr = ROW_W'(cy_q);
				ram_wr.data = row_mod;
			end
			ST_ROW_X: begin
				ram_rd.en   = (int'(div_quot) < MAP_H);
				ram_rd.addr = ROW_W'(div_quot);
			end
			ST_Y_RD: begin
				ram_rd.en   = !y_off;
				ram_rd.addr = nxt_y.c[ROW_W-1:0];
			end
			default: begin
				ram_rd = '0;
				ram_wr = '0;
			end
		endcase
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		finish  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == ROW_W'(MAP_H - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = kind ? ST_DIV_X : ST_WR_RD;
				end
			end
			ST_WR_RD:  state_d = wr_in_map ? ST_WR_WB : ST_IDLE;
			ST_WR_WB:  state_d = ST_IDLE;
			ST_DIV_X:  state_d = ST_DIV_Y;
			ST_DIV_Y:  state_d = ST_ROW_X;
			ST_ROW_X:  state_d = (vx_q == '0) ? ST_COL : ST_X_STEP;
			ST_X_STEP: begin
				if (!x_free || x_last) begin
					state_d = ST_COL;
				end
			end
			ST_COL:    state_d = ST_Y_INIT;
			ST_Y_INIT: begin
				if (vy_q == '0) begin
					state_d = ST_IDLE;
					finish  = 1'b1;
				end else begin
					state_d = ST_Y_RD;
				end
			end
			ST_Y_RD:   state_d = ST_Y_CHK;
			ST_Y_CHK: begin
				if (!y_free || y_last) begin
					state_d = ST_IDLE;
					finish  = 1'b1;
				end else begin
					state_d = ST_Y_RD;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + row_addr_t'(1);
			end
		end
	end

	// command capture, sweep state and results
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					kind_q <= kind;
					cx_q   <= cell_x;
					cy_q   <= cell_y;
					free_q <= cell_free;
					px_q   <= pos_x;
					py_q   <= pos_y;
					vx_q   <= vel_x;
					vy_q   <= vel_y;
				end
			end
			ST_DIV_Y: begin
				cur_q.c <= {1'b0, div_quot};
				cur_q.r <= div_rem;
			end
			ST_ROW_X: begin
				yst_q.c <= {1'b0, div_quot};
				yst_q.r <= div_rem;
				rowok_q <= (int'(div_quot) < MAP_H);
				step_q  <= step_t'(1);
				if (vx_q == '0) begin
					new_vel_x_q <= vx_q;
					hit_x_q     <= 1'b0;
				end
			end
			ST_X_STEP: begin
				if (!x_free) begin
					new_vel_x_q <= clip_vel(step_q - step_t'(1), vx_q[VEL_W-1]);
					hit_x_q     <= 1'b1;
				end else if (x_last) begin
					new_vel_x_q <= vx_q;
					hit_x_q     <= 1'b0;
				end else begin
					cur_q  <= nxt_x;
					step_q <= step_q + step_t'(1);
				end
			end
			ST_COL: begin
				colneg_q <= col_sum[POS_W+1];
			end
			ST_Y_INIT: begin
				colok_q <= !colneg_q && (int'(div_quot) < MAP_W);
				colc_q  <= COL_W'(div_quot);
				cur_q   <= yst_q;
				step_q  <= step_t'(1);
				if (vy_q == '0) begin
					new_vel_y_q <= vy_q;
					hit_y_q     <= 1'b0;
				end
			end
			ST_Y_RD: begin
				nxt_q <= nxt_y;
				off_q <= y_off;
			end
			ST_Y_CHK: begin
				if (!y_free) begin
					new_vel_y_q <= clip_vel(step_q - step_t'(1), vy_q[VEL_W-1]);
					hit_y_q     <= 1'b1;
				end else if (y_last) begin
					new_vel_y_q <= vy_q;
					hit_y_q     <= 1'b0;
				end else begin
					cur_q  <= nxt_q;
					step_q <= step_q + step_t'(1);
				end
			end
			default: begin
				kind_q <= kind_q;
			end
		endcase
	end

	assign done      = done_q;
	assign new_vel_x = new_vel_x_q;
	assign new_vel_y = new_vel_y_q;
	assign hit_x     = hit_x_q;
	assign hit_y     = hit_y_q;

	// a result is a single-cycle pulse
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// a result follows a cycle of query work
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && kind_q)
		else $error("result strobe without a query in progress");

	// the row memory never sees a read and a write together
	a_ram_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_rd.en && ram_wr.en))
		else $error("row memory read and write in the same cycle");

	// the x step counter stays within the step count
	a_x_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_X_STEP) |-> (step_q != '0) && (step_q <= nx))
		else $error("x step counter out of range");

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// testbench for the grid mask velocity clip block: map writes and swept collision queries
module tb;

	import gmvc_pkg::*;

	localparam int  MAP_COLS     = 512;
	localparam int  MAP_ROWS     = 512;
	localparam int  CELL_UNITS   = 6;
	localparam int  FRAC_ONE     = 256;
	localparam bit  KIND_WRITE   = 1'b0;
	localparam bit  KIND_QUERY   = 1'b1;
	localparam int  RAND_ITEMS   = 1680;
	localparam int  DRAIN_CYCLES = 400;
	localparam int  STALL_LIMIT  = 4000;
	localparam int  PRINT_CAP    = 40;

	typedef struct packed {
		logic                              kind;
		logic [gmvc_pkg::CELL_FIELD_W-1:0] cx;
		logic [gmvc_pkg::CELL_FIELD_W-1:0] cy;
		logic                              cf;
		logic [gmvc_pkg::POS_W-1:0]        px;
		logic [gmvc_pkg::POS_W-1:0]        py;
		vel_t                              vx;
		vel_t                              vy;
	} grid_cmd_t;

	typedef struct packed {
		vel_t vx;
		vel_t vy;
		logic hx;
		logic hy;
	} clip_res_t;

	typedef struct packed {
		grid_cmd_t cmd;
		logic      typed;
		clip_res_t res;
	} tab_row_t;

	logic                              clk;
	logic                              arst_n;
	logic                              start;
	logic                              busy;
	logic                              kind;
	logic [gmvc_pkg::CELL_FIELD_W-1:0] cell_x;
	logic [gmvc_pkg::CELL_FIELD_W-1:0] cell_y;
	logic                              cell_free;
	logic [gmvc_pkg::POS_W-1:0]        pos_x;
	logic [gmvc_pkg::POS_W-1:0]        pos_y;
	vel_t                              vel_x;
	vel_t                              vel_y;
	logic                              done;
	vel_t                              new_vel_x;
	vel_t                              new_vel_y;
	logic                              hit_x;
	logic                              hit_y;

	// mirror of the free map, one bit per cell
	bit [MAP_COLS-1:0] free_rows [MAP_ROWS];
	clip_res_t         pending_clips [$];
	tab_row_t          directed_tab [$];
	clip_res_t         want;
	int                mismatch_cnt = 0;
	int                send_idle    = 0;
	int                items_sent   = 0;
	int                idle_cycles  = 0;

	grid_mask_velocity_clip i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.kind      (kind),
		.cell_x    (cell_x),
		.cell_y    (cell_y),
		.cell_free (cell_free),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.vel_x     (vel_x),
		.vel_y     (vel_y),
		.done      (done),
		.new_vel_x (new_vel_x),
		.new_vel_y (new_vel_y),
		.hit_x     (hit_x),
		.hit_y     (hit_y)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// cell index of a position with 8 fraction bits, -1 below zero
	function automatic longint cell_index(longint p);
		if (p < 0) return -1;
		return p / (CELL_UNITS * FRAC_ONE);
	endfunction

	// off-map cells read as wall
	function automatic bit cell_open(longint cx, longint cy);
		if (cx < 0 || cy < 0 || cx >= MAP_COLS || cy >= MAP_ROWS) return 1'b0;
		return free_rows[int'(cy)][int'(cx)];
	endfunction

	// whole-unit sweep along one axis, clipped to the free steps before a wall
	function automatic vel_t sweep_axis(longint p, longint v, longint other, bit along_x,
			output bit hit);
		longint steps;
		longint dir;
		longint c;
		bit     clear;
		hit = 1'b0;
		if (v == 0) return vel_t'(v);
		dir   = (v > 0) ? 1 : -1;
		steps = (((v > 0) ? v : -v) + FRAC_ONE - 1) / FRAC_ONE;
		for (longint i = 1; i <= steps; i++) begin
			c     = cell_index(p + dir * i * FRAC_ONE);
			clear = along_x ? cell_open(c, other) : cell_open(other, c);
			if (!clear) begin
				hit = 1'b1;
				return vel_t'(dir * (i - 1) * FRAC_ONE);
			end
		end
		return vel_t'(v);
	endfunction

	// x sweep in the row of pos_y, then y sweep in the column of pos_x + clipped x
	function automatic clip_res_t predict_clip(grid_cmd_t c);
		clip_res_t r;
		bit        hx;
		bit        hy;
		longint    px;
		longint    py;
		px   = longint'(c.px);
		py   = longint'(c.py);
		r.vx = sweep_axis(px, longint'($signed(c.vx)), cell_index(py), 1'b1, hx);
		r.vy = sweep_axis(py, longint'($signed(c.vy)), cell_index(px + $signed(r.vx)), 1'b0,
			hy);
		r.hx = hx;
		r.hy = hy;
		return r;
	endfunction

	function automatic void tab_add(bit k, int cx, int cy, int cf, int px, int py, int vx, int vy,
			bit typed = 1'b0, int evx = 0, int evy = 0, bit ehx = 1'b0, bit ehy = 1'b0);
		tab_row_t row;
		row.cmd.kind = k;
		row.cmd.cx   = CELL_FIELD_W'(cx);
		row.cmd.cy   = CELL_FIELD_W'(cy);
		row.cmd.cf   = 1'(cf);
		row.cmd.px   = POS_W'(px);
		row.cmd.py   = POS_W'(py);
		row.cmd.vx   = vel_t'(vx);
		row.cmd.vy   = vel_t'(vy);
		row.typed    = typed;
		row.res.vx   = vel_t'(evx);
		row.res.vy   = vel_t'(evy);
		row.res.hx   = ehx;
		row.res.hy   = ehy;
		directed_tab.push_back(row);
	endfunction

	// every field random over its full width
	function automatic grid_cmd_t rand_cmd();
		grid_cmd_t c;
		c.kind = 1'($urandom_range(0, 1));
		c.cx   = CELL_FIELD_W'($urandom_range(0, MAP_COLS - 1));
		c.cy   = CELL_FIELD_W'($urandom_range(0, MAP_ROWS - 1));
		c.cf   = 1'($urandom_range(0, 1));
		c.px   = POS_W'($urandom);
		c.py   = POS_W'($urandom);
		c.vx   = vel_t'($urandom);
		c.vy   = vel_t'($urandom);
		return c;
	endfunction

	// bias towards the two map edges so that written areas overlap
	function automatic int pick_base();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return $urandom_range(0, 24);
		if (r < 80) return $urandom_range(MAP_COLS - 25, MAP_COLS - 1);
		return $urandom_range(0, MAP_COLS - 1);
	endfunction

	function automatic int window_cell(int base, int w);
		int c;
		c = base + $urandom_range(0, w - 1);
		return (c >= MAP_COLS) ? MAP_COLS - 1 : c;
	endfunction

	function automatic vel_t rand_vel(int w);
		int m;
		int mag;
		m = $urandom_range(0, 99);
		if (m < 8) return '0;
		if (m >= 92) return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		if (m < 80) mag = $urandom_range(1, w * CELL_UNITS * FRAC_ONE);
		else mag = $urandom_range(1, 32767);
		return $urandom_range(0, 1) ? vel_t'(-mag) : vel_t'(mag);
	endfunction

	task automatic report_mismatch(string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= PRINT_CAP) $display("mismatch: %s", msg);
	endtask

	// one command transfer, then update the map mirror or queue the expected clip
	task automatic issue(grid_cmd_t c, bit typed = 1'b0, clip_res_t fixed_res = '0);
		while ($urandom_range(0, 99) < send_idle) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start     <= 1'b1;
		kind      <= c.kind;
		cell_x    <= c.cx;
		cell_y    <= c.cy;
		cell_free <= c.cf;
		pos_x     <= c.px;
		pos_y     <= c.py;
		vel_x     <= c.vx;
		vel_y     <= c.vy;
		do @(posedge clk); while (busy !== 1'b0);
		items_sent++;
		if (c.kind == KIND_WRITE) begin
			if (c.cx < MAP_COLS && c.cy < MAP_ROWS) free_rows[c.cy][c.cx] = c.cf;
		end else begin
			pending_clips.push_back(typed ? fixed_res : predict_clip(c));
		end
	endtask

	// result check and stall watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (arst_n && done) begin
			if (pending_clips.size() == 0) begin
				report_mismatch($sformatf("stray result: vx %0d vy %0d hx %0b hy %0b",
					new_vel_x, new_vel_y, hit_x, hit_y));
			end else begin
				want = pending_clips.pop_front();
				if (new_vel_x !== want.vx || new_vel_y !== want.vy || hit_x !== want.hx ||
						hit_y !== want.hy)
					report_mismatch($sformatf("got %0d %0d %0b %0b, want %0d %0d %0b %0b",
						new_vel_x, new_vel_y, hit_x, hit_y,
						want.vx, want.vy, want.hx, want.hy));
			end
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// stimulus
	initial begin
		int        phase_idle [4];
		grid_cmd_t c;
		int        bx;
		int        by;
		int        w;
		int        target;
		phase_idle = '{0, 84, 0, 13};
		arst_n    <= 1'b0;
		start     <= 1'b0;
		kind      <= KIND_WRITE;
		cell_x    <= '0;
		cell_y    <= '0;
		cell_free <= 1'b0;
		pos_x     <= '0;
		pos_y     <= '0;
		vel_x     <= '0;
		vel_y     <= '0;
		foreach (free_rows[r]) free_rows[r] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: all-wall map after reset, extremes, then a small free patch at two opposite corners
		tab_add(KIND_QUERY, $urandom, $urandom, $urandom, 0, 0, 0, 0, 1'b1, 0, 0, 1'b0, 1'b0);
		tab_add(KIND_QUERY, $urandom, $urandom, $urandom, 20'hFFFFF, 20'hFFFFF, 32767, -32768,
			1'b1, 0, 0, 1'b1, 1'b1);
		tab_add(KIND_QUERY, $urandom, $urandom, $urandom, 0, 0, -32768, 32767,
			1'b1, 0, 0, 1'b1, 1'b1);
		tab_add(KIND_WRITE, 0, 0, 1'b1, $urandom, $urandom, $urandom, $urandom);
		tab_add(KIND_WRITE, 1, 0, 1'b1, 20'hFFFFF, 20'hFFFFF, -1, -1);
		tab_add(KIND_WRITE, 2, 0, 1'b1, $urandom, $urandom, $urandom, $urandom);
		tab_add(KIND_WRITE, 3, 0, 1'b1, $urandom, $urandom, $urandom, $urandom);
		tab_add(KIND_WRITE, 0, 1, 1'b1, $urandom, $urandom, $urandom, $urandom);
		tab_add(KIND_WRITE, 0, 2, 1'b1, $urandom, $urandom, $urandom, $urandom);
		tab_add(KIND_WRITE, 511, 511, 1'b1, 0, 0, 0, 0);
		tab_add(KIND_WRITE, 510, 511, 1'b1, $urandom, $urandom, $urandom, $urandom);
		tab_add(KIND_WRITE, 511, 510, 1'b1, $urandom, $urandom, $urandom, $urandom);
		tab_add(KIND_QUERY, 511, 511, 1'b1, 0, 0, 4 * CELL_UNITS * FRAC_ONE, 0);
		tab_add(KIND_QUERY, 0, 0, 1'b0, 1 * FRAC_ONE, 0, -512, 3000);
		tab_add(KIND_QUERY, $urandom, $urandom, $urandom, 8'h80, 8'h80, 0, 32767);
		// negative column: first x step falls below zero
		tab_add(KIND_QUERY, $urandom, $urandom, $urandom, 0, 0, -1, 0,
			1'b1, 0, 0, 1'b1, 1'b0);
		tab_add(KIND_WRITE, 1, 0, 1'b0, $urandom, $urandom, $urandom, $urandom);
		tab_add(KIND_QUERY, $urandom, $urandom, $urandom, 0, 0, 32767, 32767);
		tab_add(KIND_QUERY, $urandom, $urandom, $urandom, 3071 * FRAC_ONE + 255,
			3071 * FRAC_ONE + 255, 1, -1536);
		tab_add(KIND_QUERY, $urandom, $urandom, $urandom, 3071 * FRAC_ONE + 255,
			3071 * FRAC_ONE + 255, -1, -32768);
		tab_add(KIND_QUERY, $urandom, $urandom, $urandom, 3066 * FRAC_ONE, 3066 * FRAC_ONE,
			-32768, -32768);
		tab_add(KIND_WRITE, 511, 511, 1'b0, 20'hFFFFF, 20'hFFFFF, -32768, -32768);
		tab_add(KIND_QUERY, 0, 0, 1'b0, 3071 * FRAC_ONE, 3070 * FRAC_ONE, 0, 32767);
		foreach (directed_tab[i]) issue(directed_tab[i].cmd, directed_tab[i].typed,
			directed_tab[i].res);

		// random: episodes of writes around a base cell followed by queries in that patch
		target = items_sent;
		for (int p = 0; p < 4; p++) begin
			send_idle = phase_idle[p];
			target += RAND_ITEMS / 4;
			while (items_sent < target) begin
				if ($urandom_range(0, 99) < 20) begin
					repeat ($urandom_range(1, 3)) issue(rand_cmd());
				end else begin
					bx = pick_base();
					by = pick_base();
					w  = $urandom_range(3, 8);
					repeat ($urandom_range(4, 16)) begin
						c      = rand_cmd();
						c.kind = KIND_WRITE;
						c.cx   = CELL_FIELD_W'(window_cell(bx, w));
						c.cy   = CELL_FIELD_W'(window_cell(by, w));
						c.cf   = ($urandom_range(0, 99) < 85);
						issue(c);
					end
					repeat ($urandom_range(2, 6)) begin
						c      = rand_cmd();
						c.kind = KIND_QUERY;
						c.px   = POS_W'((window_cell(bx, w) * CELL_UNITS
							+ $urandom_range(0, CELL_UNITS - 1)) * FRAC_ONE
							+ $urandom_range(0, FRAC_ONE - 1));
						c.py   = POS_W'((window_cell(by, w) * CELL_UNITS
							+ $urandom_range(0, CELL_UNITS - 1)) * FRAC_ONE
							+ $urandom_range(0, FRAC_ONE - 1));
						c.vx   = rand_vel(w);
						c.vy   = rand_vel(w);
						issue(c);
					end
				end
			end
		end
		start <= 1'b0;

		// drain outstanding clips, then let a final query or write settle
		while (pending_clips.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
